@@ hdl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the source text tokenizer
// Token kinds, token word layout, character constants and byte classifiers.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int POS_BITS  = 16;
    localparam int LEN_BITS  = 8;
    localparam int KIND_BITS = 5;
    localparam int MAX_RES   = 3;

    localparam logic [LEN_BITS-1:0] LEN_CAP = 8'd255;

    // token kinds
    localparam logic [KIND_BITS-1:0] K_LPAREN     = 5'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN     = 5'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE     = 5'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE     = 5'd3;
    localparam logic [KIND_BITS-1:0] K_LBRACKET   = 5'd4;
    localparam logic [KIND_BITS-1:0] K_RBRACKET   = 5'd5;
    localparam logic [KIND_BITS-1:0] K_LESS       = 5'd6;
    localparam logic [KIND_BITS-1:0] K_GREATER    = 5'd7;
    localparam logic [KIND_BITS-1:0] K_COLON      = 5'd8;
    localparam logic [KIND_BITS-1:0] K_SEMI       = 5'd9;
    localparam logic [KIND_BITS-1:0] K_COMMA      = 5'd10;
    localparam logic [KIND_BITS-1:0] K_DOT        = 5'd11;
    localparam logic [KIND_BITS-1:0] K_PLUS       = 5'd12;
    localparam logic [KIND_BITS-1:0] K_MINUS      = 5'd13;
    localparam logic [KIND_BITS-1:0] K_STAR       = 5'd14;
    localparam logic [KIND_BITS-1:0] K_SLASH      = 5'd15;
    localparam logic [KIND_BITS-1:0] K_PERCENT    = 5'd16;
    localparam logic [KIND_BITS-1:0] K_EQUALS     = 5'd17;
    localparam logic [KIND_BITS-1:0] K_ARROW      = 5'd18;
    localparam logic [KIND_BITS-1:0] K_IDENT      = 5'd19;
    localparam logic [KIND_BITS-1:0] K_NUMBER     = 5'd20;
    localparam logic [KIND_BITS-1:0] K_UNEXPECTED = 5'd21;
    localparam logic [KIND_BITS-1:0] K_END        = 5'd22;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_DOT        = 8'h2E;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [15:0]          start_pos;
        logic [LEN_BITS-1:0]  length;
        logic                 length_saturated;
        logic [7:0]           bad_byte;
    } tok_t;

    function automatic tok_t make_tok(input logic [KIND_BITS-1:0] kind,
                                      input logic [POS_BITS-1:0]  start,
                                      input logic [LEN_BITS-1:0]  len,
                                      input logic                 sat,
                                      input logic [7:0]           bad);
        tok_t t;
        t.kind             = kind;
        t.start_pos        = 16'(start);
        t.length           = len;
        t.length_saturated = sat;
        t.bad_byte         = bad;
        return t;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // single-byte token decode; valid is low for any other byte
    function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS:0] r;
        r = {1'b1, K_LPAREN};
        unique case (c)
            8'h28:   r = {1'b1, K_LPAREN};
            8'h29:   r = {1'b1, K_RPAREN};
            8'h7B:   r = {1'b1, K_LBRACE};
            8'h7D:   r = {1'b1, K_RBRACE};
            8'h5B:   r = {1'b1, K_LBRACKET};
            8'h5D:   r = {1'b1, K_RBRACKET};
            8'h3C:   r = {1'b1, K_LESS};
            8'h3E:   r = {1'b1, K_GREATER};
            8'h3A:   r = {1'b1, K_COLON};
            8'h3B:   r = {1'b1, K_SEMI};
            8'h2C:   r = {1'b1, K_COMMA};
            8'h2E:   r = {1'b1, K_DOT};
            8'h2B:   r = {1'b1, K_PLUS};
            8'h2D:   r = {1'b1, K_MINUS};
            8'h2A:   r = {1'b1, K_STAR};
            8'h2F:   r = {1'b1, K_SLASH};
            8'h25:   r = {1'b1, K_PERCENT};
            default: r = {1'b0, K_LPAREN};
        endcase
        return r;
    endfunction

endpackage

@@ hdl/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream lexer: punctuation, '=' / '=>', identifiers, numbers, end token.
// ----------------------------------------------------------------------------
//  port group | dir | tdata                  | tuser     | tlast
//  s_*        | in  | ch                     | has_char  | is_end
//  m_*        | out | start_pos,len,sat,bad  | kind      | last token of word
//
//  One input word per cycle while s_tready is high; its 0..3 tokens are built
//  in the same cycle, held in a token bundle register, then sent one per cycle
//  while m_tready is high. A word giving at most one token sustains one word
//  per cycle; a word giving more holds the input until its last token leaves.
//  s_tready is high when the bundle is empty or its last token leaves now.
//  Synchronous active-low reset clears mode, position and the bundle.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] has_char
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] start_pos, [23:16] length,
                                   // [24] length_saturated, [32:25] bad_byte
    output logic [4:0]  m_tuser,   // [4:0] kind
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_EQ
    } lex_mode_t;

    localparam int PB = stt_pkg::POS_BITS;
    localparam int LB = stt_pkg::LEN_BITS;

    lex_mode_t           mode_reg,  mode_next;
    logic [PB-1:0]       start_reg, start_next;
    logic [LB-1:0]       len_reg,   len_next;
    logic                over_reg,  over_next;
    logic [PB-1:0]       pos_reg,   pos_next;

    stt_pkg::tok_t       tok_reg  [stt_pkg::MAX_RES];
    stt_pkg::tok_t       tok_next [stt_pkg::MAX_RES];
    logic [1:0]          cnt_reg, cnt_next;
    logic [1:0]          idx_reg;

    logic [7:0]          ch;
    logic                s_acc, m_acc, out_last;

    assign ch       = s_tdata;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign out_last = (idx_reg == (cnt_reg - 2'd1));
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (m_acc && out_last);
    assign s_acc    = s_tvalid && s_tready;

    assign m_tuser  = tok_reg[idx_reg].kind;
    assign m_tlast  = out_last;
    assign m_tdata  = {7'd0, tok_reg[idx_reg].bad_byte, tok_reg[idx_reg].length_saturated,
                       tok_reg[idx_reg].length, tok_reg[idx_reg].start_pos};

    // Build the bundle for the word at the input, in this order:
    // byte (with flush of the pending token), position advance, end handling.
    always_comb begin
        logic                       cont;
        logic [stt_pkg::KIND_BITS:0] pk;
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        over_next  = over_reg;
        pos_next   = pos_reg;
        cnt_next   = 2'd0;
        cont       = 1'b0;
        pk         = stt_pkg::punct_kind(ch);
        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
            tok_next[i] = tok_reg[i];
        end

        if (s_tuser) begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    if (stt_pkg::is_letter(ch) || stt_pkg::is_digit(ch)) begin
                        cont = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (stt_pkg::is_digit(ch) || ch == stt_pkg::CH_DOT) begin
                        cont = 1'b1;
                    end
                end
                MODE_EQ: begin
                    if (ch == stt_pkg::CH_GREATER) begin
                        cont = 1'b1;
                        tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_ARROW, start_reg,
                                                               8'd2, 1'b0, 8'd0);
                        cnt_next  = cnt_next + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                default: cont = 1'b0;
            endcase

            if (cont && (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER)) begin
                if (len_reg < stt_pkg::LEN_CAP) begin
                    len_next = len_reg + 1'b1;
                end else begin
                    over_next = 1'b1;
                end
            end

            if (!cont) begin
                // flush whatever was pending, then handle the byte from idle
                unique case (mode_reg)
                    MODE_IDENT: begin
                        tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_IDENT, start_reg,
                                                               len_reg, over_reg, 8'd0);
                        cnt_next = cnt_next + 2'd1;
                    end
                    MODE_NUMBER: begin
                        tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_NUMBER, start_reg,
                                                               len_reg, over_reg, 8'd0);
                        cnt_next = cnt_next + 2'd1;
                    end
                    MODE_EQ: begin
                        tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_EQUALS, start_reg,
                                                               8'd1, 1'b0, 8'd0);
                        cnt_next = cnt_next + 2'd1;
                    end
                    default: cnt_next = cnt_next;
                endcase
                mode_next = MODE_IDLE;

                if (pk[stt_pkg::KIND_BITS]) begin
                    tok_next[cnt_next] = stt_pkg::make_tok(pk[stt_pkg::KIND_BITS-1:0],
                                                           pos_reg, 8'd1, 1'b0, 8'd0);
                    cnt_next = cnt_next + 2'd1;
                end else if (ch == stt_pkg::CH_SPACE) begin
                    mode_next = MODE_IDLE;
                end else if (ch == stt_pkg::CH_EQUALS || stt_pkg::is_letter(ch) ||
                             stt_pkg::is_digit(ch)) begin
                    mode_next  = (ch == stt_pkg::CH_EQUALS) ? MODE_EQ :
                                 stt_pkg::is_letter(ch) ? MODE_IDENT : MODE_NUMBER;
                    start_next = pos_reg;
                    len_next   = 8'd1;
                    over_next  = 1'b0;
                end else begin
                    tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_UNEXPECTED, pos_reg,
                                                           8'd1, 1'b0, ch);
                    cnt_next = cnt_next + 2'd1;
                end
            end
            pos_next = pos_reg + 1'b1;
        end

        if (s_tlast) begin
            unique case (mode_next)
                MODE_IDENT: begin
                    tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_IDENT, start_next,
                                                           len_next, over_next, 8'd0);
                    cnt_next = cnt_next + 2'd1;
                end
                MODE_NUMBER: begin
                    tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_NUMBER, start_next,
                                                           len_next, over_next, 8'd0);
                    cnt_next = cnt_next + 2'd1;
                end
                MODE_EQ: begin
                    tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_EQUALS, start_next,
                                                           8'd1, 1'b0, 8'd0);
                    cnt_next = cnt_next + 2'd1;
                end
                default: cnt_next = cnt_next;
            endcase
            tok_next[cnt_next] = stt_pkg::make_tok(stt_pkg::K_END, pos_next,
                                                   8'd0, 1'b0, 8'd0);
            cnt_next   = cnt_next + 2'd1;
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            over_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            over_reg  <= 1'b0;
            pos_reg   <= '0;
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end else begin
            if (s_acc) begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                over_reg  <= over_next;
                pos_reg   <= pos_next;
                cnt_reg   <= cnt_next;
                idx_reg   <= 2'd0;
                for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
                    tok_reg[i] <= tok_next[i];
                end
            end else if (m_acc) begin
                if (out_last) begin
                    cnt_reg <= 2'd0;
                    idx_reg <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // ---- assertions ----
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg < cnt_reg))
        else $error("token index beyond bundle count");

    a_idx_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(idx_reg) && $stable(cnt_reg))
        else $error("bundle moved while output stalled");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || (m_tready && out_last)))
        else $error("input taken while bundle still pending");

    a_eq_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_EQ) |-> (len_reg == 8'd1 && !over_reg))
        else $error("pending '=' with bad length");

    a_pending_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER) |-> (len_reg != 8'd0))
        else $error("pending token with zero length");

endmodule
